>>> sv/itf_pkg.sv
// ----------------------------------------------------------------------------
// itf_pkg: shared types and constants of the integer text formatter
// Conversion codes, the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package itf_pkg;

	localparam int unsigned MAX_FIELD_DEF = 64;
	localparam int unsigned MAX_PREC_DEF  = 40;
	localparam int unsigned DIG_DEPTH     = 22;
	localparam int unsigned DIG_AW        = 5;

	localparam logic [2:0] MODE_SDEC = 3'd0;
	localparam logic [2:0] MODE_UDEC = 3'd1;
	localparam logic [2:0] MODE_OCT  = 3'd2;
	localparam logic [2:0] MODE_HEXL = 3'd3;
	localparam logic [2:0] MODE_HEXU = 3'd4;
	localparam logic [2:0] MODE_CHAR = 3'd5;

	localparam logic [2:0] LEN_HH = 3'd0;
	localparam logic [2:0] LEN_H  = 3'd1;
	localparam logic [2:0] LEN_W  = 3'd2;
	localparam logic [2:0] LEN_L  = 3'd3;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Output segments, the first five in emission order.
	localparam logic [2:0] SEG_LPAD  = 3'd0;
	localparam logic [2:0] SEG_PRE   = 3'd1;
	localparam logic [2:0] SEG_ZEROS = 3'd2;
	localparam logic [2:0] SEG_DIGS  = 3'd3;
	localparam logic [2:0] SEG_RPAD  = 3'd4;
	localparam logic [2:0] SEG_CHAR  = 3'd5;

	typedef struct packed {
		logic load;
		logic digit_step;
		logic plan;
		logic emit;
		logic emit_single;
		logic single_err;
	} itf_cmd_t;

	typedef struct packed {
		logic input_error;
		logic digits_done;
		logic emit_done;
	} itf_sts_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		if (d < 4'd10)
			return CH_ZERO + {4'd0, d};
		return (upper ? CH_UA : CH_LA) + {4'd0, d - 4'd10};
	endfunction

endpackage

>>> sv/integer_text_formatter.sv
// ----------------------------------------------------------------------------
// integer_text_formatter: printf-style integer and character conversion
// Turns one parsed conversion into its characters, one per strobe.
// ----------------------------------------------------------------------------
// Usage: drive the conversion fields and pulse start while busy is low; the
// transaction is taken at that edge and the fields need not be held after it.
// The block checks the flags, then produces the digits: a shift per digit
// for octal and hex, and for decimal a shift-and-add estimate of the value
// over ten with a one-step remainder fix. It then plans the layout and
// emits one character per cycle on out_char with strobe high; strobe stays
// low while it steps past a finished or empty segment, and last_char marks
// the final character. A rejected conversion gives one strobe with
// format_error set; an empty text gives one with empty_text. busy is low
// again in the cycle that shows the last strobe, and a new transaction may
// be taken in that cycle. The receiver cannot stall. Reset clears the
// controller and the strobe.
// ----------------------------------------------------------------------------
module integer_text_formatter #(
	parameter int unsigned MAX_FIELD     = itf_pkg::MAX_FIELD_DEF,
	parameter int unsigned MAX_PRECISION = itf_pkg::MAX_PREC_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [63:0]       arg_value,
	input  logic [2:0]        mode,
	input  logic [2:0]        length_code,
	input  logic              left_justify,
	input  logic              force_sign,
	input  logic              space_sign,
	input  logic              alt_form,
	input  logic              zero_pad,
	input  logic [6:0]        field_width,
	input  logic signed [6:0] digit_precision,
	output logic              strobe,
	output logic [7:0]        out_char,
	output logic              last_char,
	output logic              format_error,
	output logic              empty_text
);

	itf_pkg::itf_cmd_t cmd;
	itf_pkg::itf_sts_t sts;

	itf_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.sts   (sts)
	);

	itf_dp #(
		.MAX_FIELD    (MAX_FIELD),
		.MAX_PRECISION(MAX_PRECISION)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.arg_value      (arg_value),
		.mode           (mode),
		.length_code    (length_code),
		.left_justify   (left_justify),
		.force_sign     (force_sign),
		.space_sign     (space_sign),
		.alt_form       (alt_form),
		.zero_pad       (zero_pad),
		.field_width    (field_width),
		.digit_precision(digit_precision),
		.strobe         (strobe),
		.out_char       (out_char),
		.last_char      (last_char),
		.format_error   (format_error),
		.empty_text     (empty_text)
	);

endmodule

>>> sv/itf_ctrl.sv
// ----------------------------------------------------------------------------
// itf_ctrl: controller of the integer text formatter
// Sequences load, digit generation, layout planning and character emission.
// ----------------------------------------------------------------------------
module itf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output itf_pkg::itf_cmd_t cmd,
	input  itf_pkg::itf_sts_t sts
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIG   = 3'd2;
	localparam logic [2:0] ST_PLAN  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (start) state_q <= ST_CHECK;
				ST_CHECK: state_q <= sts.input_error ? ST_IDLE : ST_DIG;
				ST_DIG:   if (sts.digits_done) state_q <= ST_PLAN;
				ST_PLAN:  state_q <= ST_EMIT;
				ST_EMIT:  if (sts.emit_done) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd             = '0;
		cmd.load        = (state_q == ST_IDLE) && start;
		cmd.emit_single = (state_q == ST_CHECK) && sts.input_error;
		cmd.single_err  = 1'b1;
		cmd.digit_step  = (state_q == ST_DIG) && !sts.digits_done;
		cmd.plan        = (state_q == ST_PLAN);
		cmd.emit        = (state_q == ST_EMIT);
	end

endmodule

>>> sv/itf_dp.sv
// ----------------------------------------------------------------------------
// itf_dp: datapath of the integer text formatter
// Holds the operands, peels one digit at a time and emits the laid-out text.
// ----------------------------------------------------------------------------
module itf_dp #(
	parameter int unsigned MAX_FIELD     = itf_pkg::MAX_FIELD_DEF,
	parameter int unsigned MAX_PRECISION = itf_pkg::MAX_PREC_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  itf_pkg::itf_cmd_t cmd,
	output itf_pkg::itf_sts_t sts,
	input  logic [63:0]       arg_value,
	input  logic [2:0]        mode,
	input  logic [2:0]        length_code,
	input  logic              left_justify,
	input  logic              force_sign,
	input  logic              space_sign,
	input  logic              alt_form,
	input  logic              zero_pad,
	input  logic [6:0]        field_width,
	input  logic signed [6:0] digit_precision,
	output logic              strobe,
	output logic [7:0]        out_char,
	output logic              last_char,
	output logic              format_error,
	output logic              empty_text
);

	localparam int unsigned CW = 8;
	localparam int unsigned DIG_IDX = itf_pkg::DIG_AW;

	logic [63:0] mag_q;
	logic [2:0]  mode_q;
	logic        left_q, plus_q, space_q, alt_q, zero_q;
	logic [6:0]  width_q;
	logic [6:0]  prec_q;
	logic        prec_given_q;
	logic        neg_q;
	logic        mag_nz_q;
	logic        err_q;
	logic [7:0]  char_q;
	logic [3:0]  dig_q [itf_pkg::DIG_DEPTH];
	logic [4:0]  ndig_q;
	logic [1:0]  ph_q;
	logic [63:0] qa_q;
	logic [CW-1:0] lpad_q, zeros_q, rpad_q;
	logic [1:0]  npre_q;
	logic [7:0]  pre0_q, pre1_q;
	logic [2:0]  seg_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] sent_q;
	logic        emitting_q;

	// Input decode
	logic [63:0] mask_in, mval;
	logic        sbit, input_err;
	logic [6:0]  width_sat;
	logic        pgiven;
	logic [6:0]  prec_sat;

	always_comb begin
		case (length_code)
			itf_pkg::LEN_HH: mask_in = 64'hff;
			itf_pkg::LEN_H:  mask_in = 64'hffff;
			itf_pkg::LEN_W:  mask_in = 64'hffff_ffff;
			default:         mask_in = '1;
		endcase
		mval = arg_value & mask_in;
		case (length_code)
			itf_pkg::LEN_HH: sbit = arg_value[7];
			itf_pkg::LEN_H:  sbit = arg_value[15];
			itf_pkg::LEN_W:  sbit = arg_value[31];
			default:         sbit = arg_value[63];
		endcase
		width_sat = (field_width > 7'(MAX_FIELD)) ? 7'(MAX_FIELD) : field_width;
		pgiven    = !digit_precision[6];
		prec_sat  = !pgiven ? 7'd1 :
			((digit_precision > 7'(MAX_PRECISION)) ? 7'(MAX_PRECISION) : digit_precision);
		if (mode > itf_pkg::MODE_CHAR)
			input_err = 1'b1;
		else if (mode == itf_pkg::MODE_CHAR)
			input_err = zero_pad || alt_form;
		else
			input_err = (length_code > itf_pkg::LEN_L) ||
				(alt_form && (mode == itf_pkg::MODE_SDEC || mode == itf_pkg::MODE_UDEC));
	end

	// Octal and hex take one shift per digit. Decimal steps through ph_q: phases
	// 0 and 1 build a shift-and-add estimate of 0.8 times the value, phase 2 scales
	// it to the quotient by ten, which is low by at most one, and fixes the
	// remainder with a single compare and subtract.
	logic [63:0] qa1, qa2, qb1, qb2, qc1;
	logic [63:0] q10, r10, q10f, r10f;
	logic        dfix;
	logic [3:0]  dval;
	logic [63:0] qnext;
	logic        radix_pow2;
	logic        step_now;

	always_comb begin
		qa1 = (mag_q >> 1) + (mag_q >> 2);
		qa2 = qa1 + (qa1 >> 4);
		qb1 = qa_q + (qa_q >> 8);
		qb2 = qb1 + (qb1 >> 16);
		qc1 = qa_q + (qa_q >> 32);
		q10 = qc1 >> 3;
		r10 = mag_q - ((q10 << 3) + (q10 << 1));
		dfix = (r10 > 64'd9);
		q10f = q10 + {63'd0, dfix};
		r10f = dfix ? r10 - 64'd10 : r10;
		case (mode_q)
			itf_pkg::MODE_OCT: begin
				dval = {1'b0, mag_q[2:0]};
				qnext = mag_q >> 3;
			end
			itf_pkg::MODE_HEXL, itf_pkg::MODE_HEXU: begin
				dval = mag_q[3:0];
				qnext = mag_q >> 4;
			end
			default: begin
				dval = r10f[3:0];
				qnext = q10f;
			end
		endcase
	end

	assign radix_pow2 = (mode_q == itf_pkg::MODE_OCT) || (mode_q == itf_pkg::MODE_HEXL) ||
		(mode_q == itf_pkg::MODE_HEXU);
	assign step_now = radix_pow2 || (ph_q == 2'd2);

	// Digit generation ends when the value is exhausted, or at once for an empty number or a character.
	logic skip_digits;
	assign skip_digits = (!mag_nz_q && prec_q == 7'd0) || mode_q == itf_pkg::MODE_CHAR;
	assign sts.digits_done = skip_digits || (ndig_q != 5'd0 && mag_q == 64'd0);
	assign sts.input_error = err_q;

	// Layout plan
	logic [CW-1:0] zeros_c, body_c, pad_c, zfin_c, width_e;
	logic [1:0]    npre_c;
	logic [7:0]    p0_c, p1_c;
	logic          oct_fix;

	always_comb begin
		width_e = CW'(width_q);
		zeros_c = (CW'(prec_q) > CW'(ndig_q)) ? CW'(prec_q) - CW'(ndig_q) : '0;
		oct_fix = (mode_q == itf_pkg::MODE_OCT) && alt_q && zeros_c == '0 &&
			(ndig_q == 5'd0 || dig_q[DIG_IDX'(ndig_q - 5'd1)] != 4'd0);
		if (oct_fix)
			zeros_c = CW'(1);
		npre_c = 2'd0;
		p0_c = itf_pkg::CH_MINUS;
		p1_c = itf_pkg::CH_LX;
		if (mode_q == itf_pkg::MODE_SDEC) begin
			if (neg_q) begin
				npre_c = 2'd1;
			end else if (plus_q) begin
				npre_c = 2'd1;
				p0_c = itf_pkg::CH_PLUS;
			end else if (space_q) begin
				npre_c = 2'd1;
				p0_c = itf_pkg::CH_SPACE;
			end
		end else if ((mode_q == itf_pkg::MODE_HEXL || mode_q == itf_pkg::MODE_HEXU) &&
				alt_q && mag_nz_q) begin
			npre_c = 2'd2;
			p0_c = itf_pkg::CH_ZERO;
			p1_c = (mode_q == itf_pkg::MODE_HEXU) ? itf_pkg::CH_UX : itf_pkg::CH_LX;
		end
		if (mode_q == itf_pkg::MODE_CHAR) begin
			body_c = CW'(1);
			npre_c = 2'd0;
			zeros_c = '0;
		end else begin
			body_c = CW'(npre_c) + zeros_c + CW'(ndig_q);
		end
		pad_c = (width_e > body_c) ? width_e - body_c : '0;
		zfin_c = zeros_c;
		if (zero_q && !left_q && !prec_given_q && mode_q != itf_pkg::MODE_CHAR) begin
			zfin_c = zeros_c + pad_c;
			pad_c = '0;
		end
	end

	// Emission: walk the segments, skipping the empty ones.
	logic [2:0]    seg_n;
	logic [CW-1:0] cnt_n;
	logic [7:0]    ch;
	logic          have;

	always_comb begin
		have = 1'b1;
		ch = itf_pkg::CH_SPACE;
		case (seg_q)
			itf_pkg::SEG_LPAD:  have = (cnt_q < lpad_q);
			itf_pkg::SEG_PRE: begin
				have = (cnt_q < CW'(npre_q));
				ch = (cnt_q == '0) ? pre0_q : pre1_q;
			end
			itf_pkg::SEG_ZEROS: begin
				have = (cnt_q < zeros_q);
				ch = itf_pkg::CH_ZERO;
			end
			itf_pkg::SEG_DIGS: begin
				have = (cnt_q < CW'(ndig_q));
				ch = itf_pkg::digit_char(
					dig_q[DIG_IDX'(CW'(ndig_q) - cnt_q - CW'(1))],
					mode_q == itf_pkg::MODE_HEXU);
			end
			itf_pkg::SEG_CHAR: begin
				have = (cnt_q == '0);
				ch = char_q;
			end
			default:            have = (cnt_q < rpad_q);
		endcase
		// A left-justified character is followed by its right pad.
		if (have && seg_q == itf_pkg::SEG_CHAR) begin
			seg_n = itf_pkg::SEG_RPAD;
			cnt_n = '0;
		end else if (have) begin
			seg_n = seg_q;
			cnt_n = cnt_q + CW'(1);
		end else begin
			seg_n = seg_q + 3'd1;
			cnt_n = '0;
		end
	end

	logic last_now;
	assign last_now = have && (sent_q + CW'(1) == total_q);
	assign sts.emit_done = emitting_q && ((total_q == '0) || last_now);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			left_q  <= left_justify;
			plus_q  <= force_sign;
			space_q <= space_sign;
			alt_q   <= alt_form;
			zero_q  <= zero_pad;
			width_q <= width_sat;
			prec_q  <= prec_sat;
			prec_given_q <= pgiven;
			err_q   <= input_err;
			char_q  <= arg_value[7:0];
			neg_q   <= (mode == itf_pkg::MODE_SDEC) && sbit;
			if (mode == itf_pkg::MODE_SDEC && sbit)
				mag_q <= (64'd0 - mval) & mask_in;
			else
				mag_q <= mval;
			mag_nz_q <= (mval != 64'd0);
			ndig_q <= 5'd0;
			ph_q   <= 2'd0;
		end else if (cmd.digit_step) begin
			if (step_now) begin
				dig_q[DIG_IDX'(ndig_q)] <= dval;
				ndig_q <= ndig_q + 5'd1;
				mag_q <= qnext;
				ph_q <= 2'd0;
			end else begin
				qa_q <= (ph_q == 2'd0) ? qa2 : qb2;
				ph_q <= ph_q + 2'd1;
			end
		end
		if (cmd.plan) begin
			npre_q  <= npre_c;
			pre0_q  <= p0_c;
			pre1_q  <= p1_c;
			zeros_q <= zfin_c;
			lpad_q  <= left_q ? '0 : pad_c;
			rpad_q  <= left_q ? pad_c : '0;
			total_q <= body_c + pad_c + (zfin_c - zeros_c);
			seg_q   <= (mode_q == itf_pkg::MODE_CHAR && left_q) ? itf_pkg::SEG_CHAR :
				itf_pkg::SEG_LPAD;
			cnt_q   <= '0;
			sent_q  <= '0;
		end else if (cmd.emit) begin
			seg_q <= seg_n;
			cnt_q <= cnt_n;
			if (have)
				sent_q <= sent_q + CW'(1);
		end
	end

	// A right-justified character walks its left pad, passes the empty number
	// segments and the empty right pad, and ends in the character slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			emitting_q <= 1'b0;
		else
			emitting_q <= cmd.plan || (emitting_q && !sts.emit_done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.emit_single ||
				(cmd.emit && emitting_q && (have || total_q == '0));
		end
	end

	logic [7:0] ch_sel;
	always_comb begin
		ch_sel = ch;
		if (mode_q == itf_pkg::MODE_CHAR && seg_q != itf_pkg::SEG_CHAR &&
				seg_q != itf_pkg::SEG_LPAD && seg_q != itf_pkg::SEG_RPAD)
			ch_sel = itf_pkg::CH_SPACE;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_single) begin
			out_char <= 8'd0;
			last_char <= 1'b1;
			format_error <= cmd.single_err;
			empty_text <= 1'b0;
		end else if (cmd.emit && total_q == '0) begin
			out_char <= 8'd0;
			last_char <= 1'b1;
			format_error <= 1'b0;
			empty_text <= 1'b1;
		end else begin
			out_char <= ch_sel;
			last_char <= last_now;
			format_error <= 1'b0;
			empty_text <= 1'b0;
		end
	end

endmodule
